// File: design/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is held.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at each rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: design/ps2kd_pkg.sv
// Types, constants and helpers of the PS/2 scancode key event decoder.
`timescale 1ns / 1ps

package ps2kd_pkg;

  localparam int KEY_COUNT = 512;
  localparam int CODE_W    = 9;
  localparam int BIT_W     = 3;
  localparam int ROW_BITS  = 1 << BIT_W;
  localparam int ROWS      = (KEY_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CNT_W     = 10;

  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [ROW_BITS-1:0]  rowdata_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [1:0]           pfx_t;
  typedef logic [1:0]           op_t;

  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] PFX0_BYTE = 8'hE0;
  localparam logic [7:0] PFX1_BYTE = 8'hE1;

  localparam code_t PFX0_BASE = 9'h080;
  localparam code_t PFX1_BASE = 9'h100;

  localparam pfx_t PFX_NONE = 2'd0;
  localparam pfx_t PFX_E0   = 2'd1;
  localparam pfx_t PFX_E1   = 2'd2;

  localparam op_t OP_EVENT  = 2'd0;
  localparam op_t OP_CLEAR  = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

  localparam int REG_LSHIFT = 0;
  localparam int REG_RSHIFT = 1;
  localparam int REG_LCTRL  = 2;
  localparam int REG_RCTRL  = 3;
  localparam int REG_LALT   = 4;
  localparam int REG_RALT   = 5;

  localparam code_t REG_RESET [NUM_REGS] = '{9'd42, 9'd54, 9'd29, 9'd157, 9'd56, 9'd184};

  function automatic logic in_range(input code_t code);
    return int'(code) < KEY_COUNT;
  endfunction

  function automatic row_t row_of(input code_t code);
    return ROW_W'(code >> BIT_W);
  endfunction

endpackage

// File: design/ps2_scancode_key_event_decoder.sv
// Top level of the PS/2 scancode set 1 key event decoder.
// Throughput: one byte or clear per cycle while in_stall is low; prefix, ACK
// and clear give no beat. Events pass stage 1, then the output register.
// The key-down map is a ROWS x 8 RAM read in stage 0, written back in stage 1.
// A config write stalls the input as it is taken; stage 1 reads the modifier bit.
// Reset: synchronous; per-row valid flops empty the map at once, no sweep.
`timescale 1ns / 1ps

module ps2_scancode_key_event_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_key_code,
  output logic       out_released,
  output logic       out_repeat_res,
  output logic       out_shift_held,
  output logic       out_ctrl_held,
  output logic       out_alt_held,
  output logic       out_any_pressed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  ps2kd_pkg::rowdata_t mem [ps2kd_pkg::ROWS];

  ps2kd_pkg::code_t    regs_r [ps2kd_pkg::NUM_REGS];
  ps2kd_pkg::pfx_t     pfx_r, pfx_nxt;
  logic                s1_vld_r, s1_vld_nxt;
  ps2kd_pkg::op_t      s1_op_r;
  ps2kd_pkg::code_t    s1_code_r;
  logic                s1_rel_r;
  ps2kd_pkg::reg_idx_t s1_idx_r;
  ps2kd_pkg::rowdata_t rd_data_r;
  logic [ps2kd_pkg::ROWS-1:0]     row_vld_r, row_vld_nxt;
  logic                fwd_vld_r, fwd_vld_nxt;
  ps2kd_pkg::row_t     fwd_row_r;
  ps2kd_pkg::rowdata_t fwd_data_r;
  ps2kd_pkg::cnt_t     cnt_r, cnt_nxt;
  logic [ps2kd_pkg::NUM_REGS-1:0] mod_r, mod_nxt;
  logic                out_vld_r, out_vld_nxt;
  ps2kd_pkg::code_t    out_code_r;
  logic                out_rel_r, out_rep_r, out_sh_r, out_ct_r, out_al_r, out_any_r;

  logic                s0_ack, s0_pfx, in_acc, acc_clear, acc_byte, acc_event;
  logic                cfg_acc, cfg_hit, rd_en, s1_load;
  ps2kd_pkg::code_t    s0_code, rd_code;
  ps2kd_pkg::row_t     rd_row, s1_row;
  logic                s1_ok, fwd_hit, cur_bit, s1_adv, s1_busy, ev_fire, wr_en;
  logic                clr_fire, lkp_fire;
  logic [ps2kd_pkg::BIT_W-1:0] s1_sel;
  ps2kd_pkg::rowdata_t cur_row, new_row;

  // Stage 0: decode the byte against the pending prefix, issue the map read.
  always_comb begin
    s0_ack = (pfx_r == ps2kd_pkg::PFX_NONE) && (in_data_byte == ps2kd_pkg::ACK_BYTE);
    s0_pfx = (pfx_r == ps2kd_pkg::PFX_NONE) &&
             ((in_data_byte == ps2kd_pkg::PFX0_BYTE) || (in_data_byte == ps2kd_pkg::PFX1_BYTE));
    unique case (pfx_r)
      ps2kd_pkg::PFX_E1: s0_code = ps2kd_pkg::PFX1_BASE | ps2kd_pkg::CODE_W'(in_data_byte[6:0]);
      ps2kd_pkg::PFX_E0: s0_code = ps2kd_pkg::PFX0_BASE | ps2kd_pkg::CODE_W'(in_data_byte[6:0]);
      default:           s0_code = ps2kd_pkg::CODE_W'(in_data_byte[6:0]);
    endcase
  end

  assign cfg_ready = !s1_vld_r;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (int'(cfg_index) < ps2kd_pkg::NUM_REGS);

  assign in_stall  = s1_busy || cfg_acc;
  assign in_acc    = in_valid && !in_stall;
  assign acc_clear = in_acc && in_command;
  assign acc_byte  = in_acc && !in_command;
  assign acc_event = acc_byte && !s0_ack && !s0_pfx;

  assign rd_en   = acc_event || cfg_hit;
  assign rd_code = cfg_hit ? cfg_data : s0_code;
  assign rd_row  = ps2kd_pkg::in_range(rd_code) ? ps2kd_pkg::row_of(rd_code) : '0;
  assign s1_load = acc_event || acc_clear || cfg_hit;

  always_comb begin
    pfx_nxt = pfx_r;
    if (acc_byte) begin
      if (s0_pfx) begin
        pfx_nxt = (in_data_byte == ps2kd_pkg::PFX1_BYTE) ? ps2kd_pkg::PFX_E1 : ps2kd_pkg::PFX_E0;
      end else begin
        pfx_nxt = ps2kd_pkg::PFX_NONE;
      end
    end
  end

  // Stage 1: merge read row and last write-back; events modify and write back.
  assign s1_row  = ps2kd_pkg::row_of(s1_code_r);
  assign s1_ok   = ps2kd_pkg::in_range(s1_code_r);
  assign s1_sel  = s1_code_r[ps2kd_pkg::BIT_W-1:0];
  assign fwd_hit = fwd_vld_r && (fwd_row_r == s1_row);

  always_comb begin
    if (fwd_hit) begin
      cur_row = fwd_data_r;
    end else if (s1_ok && row_vld_r[s1_row]) begin
      cur_row = rd_data_r;
    end else begin
      cur_row = '0;
    end
    cur_bit = s1_ok && cur_row[s1_sel];
    new_row = cur_row;
    new_row[s1_sel] = !s1_rel_r;
  end

  assign s1_adv   = s1_vld_r &&
                    ((s1_op_r != ps2kd_pkg::OP_EVENT) || !out_vld_r || !out_stall);
  assign s1_busy  = s1_vld_r && !s1_adv;
  assign ev_fire  = s1_adv && (s1_op_r == ps2kd_pkg::OP_EVENT);
  assign clr_fire = s1_adv && (s1_op_r == ps2kd_pkg::OP_CLEAR);
  assign lkp_fire = s1_adv && (s1_op_r == ps2kd_pkg::OP_LOOKUP);
  assign wr_en    = ev_fire && s1_ok;

  always_comb begin
    s1_vld_nxt  = s1_load || (s1_vld_r && !s1_adv);
    row_vld_nxt = row_vld_r;
    fwd_vld_nxt = fwd_vld_r;
    cnt_nxt     = cnt_r;
    mod_nxt     = mod_r;
    if (clr_fire) begin
      row_vld_nxt = '0;
      fwd_vld_nxt = 1'b0;
      cnt_nxt     = '0;
      mod_nxt     = '0;
    end
    if (wr_en) begin
      row_vld_nxt[s1_row] = 1'b1;
      fwd_vld_nxt         = 1'b1;
      if (cur_bit && s1_rel_r) begin
        cnt_nxt = cnt_r - 1'b1;
      end else if (!cur_bit && !s1_rel_r) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      for (int i = 0; i < ps2kd_pkg::NUM_REGS; i++) begin
        if (regs_r[i] == s1_code_r) begin
          mod_nxt[i] = !s1_rel_r;
        end
      end
    end
    if (lkp_fire) begin
      mod_nxt[s1_idx_r] = cur_bit;
    end
  end

  assign out_vld_nxt = ev_fire || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_row] <= new_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r     <= ps2kd_pkg::PFX_NONE;
      s1_vld_r  <= 1'b0;
      row_vld_r <= '0;
      fwd_vld_r <= 1'b0;
      cnt_r     <= '0;
      mod_r     <= '0;
      out_vld_r <= 1'b0;
      regs_r    <= ps2kd_pkg::REG_RESET;
    end else begin
      pfx_r     <= pfx_nxt;
      s1_vld_r  <= s1_vld_nxt;
      row_vld_r <= row_vld_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      cnt_r     <= cnt_nxt;
      mod_r     <= mod_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_hit) begin
        regs_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      if (cfg_hit) begin
        s1_op_r   <= ps2kd_pkg::OP_LOOKUP;
        s1_code_r <= cfg_data;
        s1_rel_r  <= 1'b0;
      end else begin
        s1_op_r   <= acc_clear ? ps2kd_pkg::OP_CLEAR : ps2kd_pkg::OP_EVENT;
        s1_code_r <= s0_code;
        s1_rel_r  <= in_data_byte[7];
      end
      s1_idx_r <= ps2kd_pkg::REG_IDX_W'(cfg_index);
    end
    if (wr_en) begin
      fwd_row_r  <= s1_row;
      fwd_data_r <= new_row;
    end
    if (ev_fire) begin
      out_code_r <= s1_code_r;
      out_rel_r  <= s1_rel_r;
      out_rep_r  <= !s1_rel_r && cur_bit;
      out_sh_r   <= mod_r[ps2kd_pkg::REG_LSHIFT] || mod_r[ps2kd_pkg::REG_RSHIFT];
      out_ct_r   <= mod_r[ps2kd_pkg::REG_LCTRL]  || mod_r[ps2kd_pkg::REG_RCTRL];
      out_al_r   <= mod_r[ps2kd_pkg::REG_LALT]   || mod_r[ps2kd_pkg::REG_RALT];
      out_any_r  <= cnt_nxt != '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_key_code    = out_code_r;
  assign out_released    = out_rel_r;
  assign out_repeat_res  = out_rep_r;
  assign out_shift_held  = out_sh_r;
  assign out_ctrl_held   = out_ct_r;
  assign out_alt_held    = out_al_r;
  assign out_any_pressed = out_any_r;

endmodule

// File: design/ps2kd_checker.sv
// Port-level checker for the key event decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ps2kd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] out_key_code,
  input logic       out_released,
  input logic       out_repeat_res,
  input logic       out_any_pressed
);

  `CHK_ASSERT_ALWAYS(a_rst_no_beat, clk, !rst_n |=> !out_valid,
                     "result beat right after reset")
  `CHK_ASSERT(a_out_hold, clk, rst_n,
              out_valid && out_stall |=> out_valid && $stable(out_key_code),
              "stalled result beat changed")
  `CHK_ASSERT(a_rel_no_rep, clk, rst_n, out_valid && out_released |-> !out_repeat_res,
              "repeat flagged on a release")
  `CHK_ASSERT(a_press_any, clk, rst_n, out_valid && !out_released |-> out_any_pressed,
              "press left no key down")

endmodule

bind ps2_scancode_key_event_decoder ps2kd_checker u_ps2kd_checker (.*);
